// ===== src/mrwt_pkg.sv =====
// Package: shared types and constants for the Miller-Rabin witness test.
package mrwt_pkg;

  localparam int unsigned DefWidth = 64;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DONE
  } mul_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_REDUCE,
    BK_POW,
    BK_SQR,
    BK_OUT
  } back_state_t;

endpackage

// ===== src/mrwt_modmul.sv =====
// Shared modular unit: add-and-double product, one operand bit per cycle.
module mrwt_modmul import mrwt_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] op_x,
  input  logic [WIDTH-1:0] op_y,
  input  logic [WIDTH-1:0] modulus,
  output logic             done,
  output logic [WIDTH-1:0] product
);

  mul_state_t state, state_next;
  logic [WIDTH-1:0] acc, xr, yr;
  logic [WIDTH:0] acc_sum, x_sum, acc_red, x_red;

  always_comb begin
    acc_sum = {1'b0, acc} + {1'b0, xr};
    acc_red = acc_sum - {1'b0, modulus};
    x_sum = {1'b0, xr} + {1'b0, xr};
    x_red = x_sum - {1'b0, modulus};
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_MUL;
      ST_MUL: if (yr == '0) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    case (state)
      ST_IDLE: begin
        acc <= '0;
        xr <= op_x;
        yr <= op_y;
      end
      ST_MUL: begin
        if (yr[0]) acc <= acc_red[WIDTH] ? acc_sum[WIDTH-1:0] : acc_red[WIDTH-1:0];
        xr <= x_red[WIDTH] ? x_sum[WIDTH-1:0] : x_red[WIDTH-1:0];
        yr <= yr >> 1;
      end
      default: ;
    endcase
  end

  assign done = (state == ST_DONE);
  assign product = acc;

endmodule

// ===== src/mrwt_front.sv =====
// Front end: accepts candidates, flags trivial verdicts, and queues every candidate with its flags.
module mrwt_front import mrwt_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WIDTH-1:0] cand,
  input  logic [WIDTH-1:0] wbase,
  output logic             q_valid,
  input  logic             q_pop,
  output logic [WIDTH-1:0] q_cand,
  output logic [WIDTH-1:0] q_base,
  output logic             q_early,
  output logic             q_prime
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned PtrW = $clog2(QueueDepth);

  logic [WIDTH-1:0] cand_q [QueueDepth];
  logic [WIDTH-1:0] base_q [QueueDepth];
  logic early_q [QueueDepth];
  logic prime_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic push, is_two, is_early;

  assign in_stall = (count == CntW'(QueueDepth));
  assign push = in_valid && !in_stall;
  assign is_two = (cand == WIDTH'(2));
  assign is_early = is_two || !cand[0] || (cand == WIDTH'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CntW'(push) - CntW'(q_pop);
    end
    if (push) begin
      cand_q[wr_ptr] <= cand;
      base_q[wr_ptr] <= wbase;
      early_q[wr_ptr] <= is_early;
      prime_q[wr_ptr] <= is_two;
    end
  end

  assign q_valid = (count != '0);
  assign q_cand = cand_q[rd_ptr];
  assign q_base = base_q[rd_ptr];
  assign q_early = early_q[rd_ptr];
  assign q_prime = prime_q[rd_ptr];

endmodule

// ===== src/mrwt_back.sv =====
// Back end: reduces the base, runs the modular power and squarings, holds the verdict.
module mrwt_back import mrwt_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_pop,
  input  logic [WIDTH-1:0] q_cand,
  input  logic [WIDTH-1:0] q_base,
  input  logic             q_early,
  input  logic             q_prime,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             prime,
  output logic             early
);

  localparam int unsigned SW = $clog2(WIDTH + 1);

  back_state_t state, state_next;
  logic [WIDTH-1:0] n, nm1, ab, xr, acc, ex, rem_new;
  logic [SW-1:0] sleft, bitpos;
  logic phase_sq, mul_start, mul_busy, mul_done, first_hit;
  logic [WIDTH-1:0] mx, my, mprod;
  logic [WIDTH:0] rem_sh, rem_sub;

  mrwt_modmul #(.WIDTH(WIDTH)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .op_x(mx), .op_y(my),
    .modulus(n), .done(mul_done), .product(mprod)
  );

  // restoring remainder of the base, one bit per cycle, built up in xr
  always_comb begin
    rem_sh = {xr, ab[WIDTH-1]};
    rem_sub = rem_sh - {1'b0, n};
    rem_new = rem_sub[WIDTH] ? rem_sh[WIDTH-1:0] : rem_sub[WIDTH-1:0];
  end

  assign first_hit = (acc == WIDTH'(1)) || (acc == nm1);

  always_comb begin
    q_pop = 1'b0;
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          state_next = q_early ? BK_OUT : BK_REDUCE;
        end
      end
      BK_REDUCE: begin
        if (bitpos == SW'(1)) state_next = BK_POW;
      end
      BK_POW: begin
        if (ex == '0 && !mul_busy) state_next = first_hit ? BK_OUT : BK_SQR;
      end
      BK_SQR: begin
        if (!mul_busy && (xr == nm1 || sleft == '0)) state_next = BK_OUT;
      end
      BK_OUT: begin
        if (!out_stall) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign mx = phase_sq ? xr : acc;
  assign my = xr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      mul_busy <= 1'b0;
      mul_start <= 1'b0;
    end else begin
      state <= state_next;
      mul_start <= 1'b0;
      if (mul_done) mul_busy <= 1'b0;
      case (state)
        BK_IDLE: begin
          if (q_valid) begin
            n <= q_cand;
            nm1 <= q_cand - WIDTH'(1);
            ex <= q_cand - WIDTH'(1);
            ab <= q_base;
            xr <= '0;
            bitpos <= SW'(WIDTH);
            sleft <= '0;
            prime <= q_prime;
            early <= q_early;
          end
        end
        BK_REDUCE: begin
          xr <= rem_new;
          ab <= ab << 1;
          bitpos <= bitpos - SW'(1);
          // strip trailing zeros of n-1, counting s
          if (!ex[0]) begin
            ex <= ex >> 1;
            sleft <= sleft + SW'(1);
          end
          acc <= WIDTH'(1);
          phase_sq <= 1'b0;
        end
        BK_POW: begin
          if (mul_done) begin
            if (!phase_sq) begin
              acc <= mprod;
              phase_sq <= 1'b1;
            end else begin
              xr <= mprod;
              ex <= ex >> 1;
              phase_sq <= 1'b0;
            end
          end else if (!mul_busy) begin
            if (ex == '0) begin
              if (first_hit) begin
                prime <= 1'b1;
              end else begin
                xr <= acc;
                phase_sq <= 1'b1;
                sleft <= sleft - SW'(1);
              end
            end else if (!phase_sq) begin
              if (ex[0]) begin
                mul_start <= 1'b1;
                mul_busy <= 1'b1;
              end else begin
                phase_sq <= 1'b1;
              end
            end else if (ex == WIDTH'(1)) begin
              // drop the square after the top exponent bit
              ex <= '0;
              phase_sq <= 1'b0;
            end else begin
              mul_start <= 1'b1;
              mul_busy <= 1'b1;
            end
          end
        end
        BK_SQR: begin
          if (mul_done) begin
            xr <= mprod;
            sleft <= sleft - SW'(1);
          end else if (!mul_busy) begin
            if (xr == nm1) begin
              prime <= 1'b1;
            end else if (sleft != '0) begin
              mul_start <= 1'b1;
              mul_busy <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = (state == BK_OUT);

endmodule

// ===== src/miller_rabin_witness_test.sv =====
// Top level: one-round Miller-Rabin witness test, front queue plus iterative back end.
//   channel | signals                              | direction
//   in      | in_valid, in_stall, candidate, base   | into block
//   out     | out_valid, out_stall, probably_prime, | out of block
//           | decided_early                        |
// Early verdicts (two, below two, even) pass through the queue and are offered without a test.
// A full test first reduces the base, then forms up to about 2*WIDTH modular
// products in turn on the shared one-bit-per-cycle multiplier.
// Synchronous reset clears the queue and both state machines.
// A stalled result holds; the front keeps accepting until its queue fills.
module miller_rabin_witness_test import mrwt_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] candidate,
  input  logic [63:0] base,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        probably_prime,
  output logic        decided_early
);

  logic q_valid, q_pop, q_early, q_prime;
  logic [WIDTH-1:0] q_cand, q_base;

  mrwt_front #(.WIDTH(WIDTH)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .cand(candidate[WIDTH-1:0]), .wbase(base[WIDTH-1:0]),
    .q_valid(q_valid), .q_pop(q_pop), .q_cand(q_cand), .q_base(q_base),
    .q_early(q_early), .q_prime(q_prime)
  );

  mrwt_back #(.WIDTH(WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop),
    .q_cand(q_cand), .q_base(q_base), .q_early(q_early), .q_prime(q_prime),
    .out_valid(out_valid), .out_stall(out_stall),
    .prime(probably_prime), .early(decided_early)
  );

endmodule
